FILE: src/gbn_pkg.sv
package gbn_pkg;

	localparam int MAX_WINDOW = 24;
	localparam int SEQ_W      = 5;
	localparam int OP_W       = 2;
	localparam int KIND_W     = 2;
	localparam int STAT_W     = 2;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [SEQ_W-1:0] WINDOW_RESET = SEQ_W'(10);

	typedef logic [SEQ_W-1:0] seq_t;

	typedef enum logic [OP_W-1:0] {
		OP_RX      = 2'd0,
		OP_SEND    = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_START = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_END   = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_SEQ_ERR  = 2'd1,
		ST_DATA_ERR = 2'd2
	} status_t;

	// Register word index decoded from paddr[PADDR_W-1:2]
	typedef enum logic {
		REG_WINDOW = 1'b0,
		REG_NONE   = 1'b1
	} reg_idx_t;

	typedef enum logic {
		ALU_INC    = 1'b0,
		ALU_REDUCE = 1'b1
	} alu_mode_t;

	typedef struct packed {
		alu_mode_t mode;
		seq_t      operand;
		seq_t      modulus;
	} alu_req_t;

	typedef struct packed {
		seq_t value;
		logic wrap;
	} alu_rsp_t;

endpackage

FILE: src/gbn_alu.sv
module gbn_alu (
	input  gbn_pkg::alu_req_t req,
	output gbn_pkg::alu_rsp_t rsp
);
	import gbn_pkg::*;

	logic [SEQ_W:0] sum;
	logic [SEQ_W:0] diff;
	logic           ge;

	// One adder and one compare/subtract serve both circular increment and
	// the reduction of an out-of-range number by the modulus.
	assign sum  = {1'b0, req.operand} + ((req.mode == ALU_INC) ? (SEQ_W+1)'(1) : '0);
	assign ge   = (sum >= {1'b0, req.modulus});
	assign diff = sum - {1'b0, req.modulus};

	always_comb begin
		rsp.wrap = ge;
		if (!ge) begin
			rsp.value = sum[SEQ_W-1:0];
		end else if (req.mode == ALU_INC) begin
			rsp.value = '0;
		end else begin
			rsp.value = diff[SEQ_W-1:0];
		end
	end

endmodule

FILE: src/go_back_n_window_controller.sv
// Channel   Direction  Handshake          Word
// in        input      in_valid/in_stall  op, rx_seq, rx_ack, rx_ok, rx_kind, new_is_end
// out       output     out_valid/out_stall transmit, tx_seq, tx_ack, is_retry, rx_status,
//                                         deliver, acked_count, sending_done, receiving, last
// cfg       APB        psel/penable/pready window_size at byte address 0
//
// Steps: one item at a time through a shared increment/reduce unit.
//   Idle takes the word, exec decodes it, release frees acknowledged frames (one
//   frame per cycle, then the stop check; good in-order receive only), mod folds the
//   expected sequence into range (a reduction only if the window shrank), then emit
//   loads the result words one at a time (n words on a timeout, else one).
// Reset: arst_n clears all sequence state and sets the window to 10.
// Stalls: out_stall holds the result register; the block waits in its emit step.
//   in_stall stays high from acceptance until the last result word is loaded.
module go_back_n_window_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [gbn_pkg::OP_W-1:0]           op,
	input  logic [gbn_pkg::SEQ_W-1:0]          rx_seq,
	input  logic [gbn_pkg::SEQ_W-1:0]          rx_ack,
	input  logic                               rx_ok,
	input  logic [gbn_pkg::KIND_W-1:0]         rx_kind,
	input  logic                               new_is_end,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               transmit,
	output logic [gbn_pkg::SEQ_W-1:0]          tx_seq,
	output logic [gbn_pkg::SEQ_W-1:0]          tx_ack,
	output logic                               is_retry,
	output logic [gbn_pkg::STAT_W-1:0]         rx_status,
	output logic                               deliver,
	output logic [gbn_pkg::SEQ_W-1:0]          acked_count,
	output logic                               sending_done,
	output logic                               receiving,
	output logic                               last,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [gbn_pkg::PADDR_W-1:0]        paddr,
	input  logic [gbn_pkg::PDATA_W-1:0]        pwdata,
	output logic [gbn_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import gbn_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_REL  = 5'b00100,
		S_MOD  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t   state_q;

	// configuration and link state
	seq_t     window_q;
	seq_t     expected_q;
	seq_t     next_tx_q;
	seq_t     oldest_q;
	seq_t     outstanding_q;
	seq_t     end_seq_q;
	logic     end_valid_q;
	logic     recv_active_q;
	logic     out_valid_q;

	// captured input word and per-item working registers
	op_t      op_q;
	seq_t     rx_seq_q;
	seq_t     rx_ack_q;
	logic     rx_ok_q;
	kind_t    rx_kind_q;
	logic     new_end_q;
	seq_t     rem_q;
	seq_t     idx_q;
	seq_t     cnt_q;
	logic     send_q;
	seq_t     send_seq_q;
	status_t  status_q;
	logic     deliver_q;
	seq_t     acked_q;

	// result register
	logic     transmit_q;
	seq_t     tx_seq_q;
	seq_t     tx_ack_q;
	logic     is_retry_q;
	status_t  rx_status_q;
	logic     deliver_out_q;
	seq_t     acked_out_q;
	logic     sending_done_q;
	logic     receiving_q;
	logic     last_q;

	seq_t     eff_win;
	seq_t     modulus;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic     accept;
	logic     load;
	logic     retry_now;
	logic     rel_step;
	logic     rx_good;
	logic     send_room;
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	function automatic logic seq_between(seq_t a, seq_t b, seq_t c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

	// Clamp the window to 1..MAX_WINDOW; sequence numbers run modulo window+1.
	always_comb begin
		if (window_q == '0) begin
			eff_win = SEQ_W'(1);
		end else if (window_q > SEQ_W'(MAX_WINDOW)) begin
			eff_win = SEQ_W'(MAX_WINDOW);
		end else begin
			eff_win = window_q;
		end
	end
	assign modulus = eff_win + SEQ_W'(1);

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign load      = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign retry_now = (cnt_q != '0);
	assign rx_good   = rx_ok_q && (rx_seq_q == expected_q);
	assign send_room = (outstanding_q < eff_win);
	assign rel_step  = (outstanding_q != '0) && seq_between(oldest_q, rx_ack_q, next_tx_q);

	// Pick the operand of the shared unit for the current step.
	always_comb begin
		alu_req.mode    = ALU_INC;
		alu_req.operand = expected_q;
		alu_req.modulus = modulus;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == OP_SEND) begin
					alu_req.operand = next_tx_q;
				end
			end
			S_REL:  alu_req.operand = oldest_q;
			S_MOD: begin
				alu_req.mode    = ALU_REDUCE;
				alu_req.operand = rem_q;
			end
			S_EMIT: alu_req.operand = idx_q;
			default: alu_req.operand = expected_q;
		endcase
	end

	gbn_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// APB: zero-wait writes, reads return the window register at its address and zero elsewhere.
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1]);
	assign cfg_wr  = psel && penable && pwrite && (cfg_idx == REG_WINDOW);

	always_comb begin
		unique case (cfg_idx)
			REG_WINDOW: prdata = {{(PDATA_W-SEQ_W){1'b0}}, window_q};
			default:    prdata = '0;
		endcase
	end

	// Control state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			window_q      <= WINDOW_RESET;
			expected_q    <= '0;
			next_tx_q     <= '0;
			oldest_q      <= '0;
			outstanding_q <= '0;
			end_seq_q     <= '0;
			end_valid_q   <= 1'b0;
			recv_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				window_q <= pwdata[SEQ_W-1:0];
			end

			// Drop the result word once taken unless a new one replaces it.
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// Only a good in-order frame goes on to release acknowledged frames.
					state_q <= ((op_q == OP_RX) && rx_good) ? S_REL : S_MOD;
					case (op_q)
						OP_RX: begin
							if (rx_good) begin
								case (rx_kind_q)
									KIND_START: recv_active_q <= 1'b1;
									KIND_END:   recv_active_q <= 1'b0;
									default:    recv_active_q <= recv_active_q;
								endcase
								expected_q <= alu_rsp.value;
							end
						end
						OP_SEND: begin
							if (send_room) begin
								if (new_end_q) begin
									end_seq_q   <= next_tx_q;
									end_valid_q <= 1'b1;
								end
								next_tx_q     <= alu_rsp.value;
								outstanding_q <= outstanding_q + SEQ_W'(1);
							end
						end
						default: ;
					endcase
				end
				S_REL: begin
					// Release one acknowledged frame per cycle.
					if (rel_step) begin
						outstanding_q <= outstanding_q - SEQ_W'(1);
						oldest_q      <= alu_rsp.value;
					end else begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (!alu_rsp.wrap) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						if (!retry_now || (cnt_q == SEQ_W'(1))) begin
							state_q <= S_IDLE;
						end
						if (retry_now && (cnt_q == SEQ_W'(1))) begin
							next_tx_q <= alu_rsp.value;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_t'(op);
			rx_seq_q   <= rx_seq;
			rx_ack_q   <= rx_ack;
			rx_ok_q    <= rx_ok;
			rx_kind_q  <= kind_t'(rx_kind);
			new_end_q  <= new_is_end;
			cnt_q      <= '0;
			send_q     <= 1'b0;
			send_seq_q <= '0;
			status_q   <= ST_OK;
			deliver_q  <= 1'b0;
			acked_q    <= '0;
		end

		case (state_q)
			S_EXEC: begin
				// Fold the advanced expected sequence on a good frame, else the current one.
				rem_q <= ((op_q == OP_RX) && rx_good) ? alu_rsp.value : expected_q;
				case (op_q)
					OP_RX: begin
						if (!rx_ok_q) begin
							status_q <= ST_DATA_ERR;
						end else if (!rx_good) begin
							status_q <= ST_SEQ_ERR;
						end else begin
							status_q  <= ST_OK;
							deliver_q <= 1'b1;
						end
					end
					OP_SEND: begin
						if (send_room) begin
							send_q     <= 1'b1;
							send_seq_q <= next_tx_q;
						end
					end
					OP_TIMEOUT: begin
						idx_q <= oldest_q;
						cnt_q <= outstanding_q;
					end
					default: ;
				endcase
			end
			S_REL: begin
				if (rel_step) begin
					acked_q <= acked_q + SEQ_W'(1);
				end
			end
			S_MOD: begin
				if (alu_rsp.wrap) begin
					rem_q <= alu_rsp.value;
				end
			end
			S_EMIT: begin
				if (load) begin
					tx_ack_q       <= (rem_q == '0) ? eff_win : rem_q - SEQ_W'(1);
					sending_done_q <= end_valid_q && (oldest_q == end_seq_q);
					receiving_q    <= recv_active_q;
					if (retry_now) begin
						// Resend the outstanding frames from the oldest.
						transmit_q    <= 1'b1;
						tx_seq_q      <= idx_q;
						is_retry_q    <= 1'b1;
						rx_status_q   <= ST_OK;
						deliver_out_q <= 1'b0;
						acked_out_q   <= '0;
						last_q        <= (cnt_q == SEQ_W'(1));
						idx_q         <= alu_rsp.value;
						cnt_q         <= cnt_q - SEQ_W'(1);
					end else begin
						transmit_q    <= send_q;
						tx_seq_q      <= send_seq_q;
						is_retry_q    <= 1'b0;
						rx_status_q   <= status_q;
						deliver_out_q <= deliver_q;
						acked_out_q   <= acked_q;
						last_q        <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign transmit     = transmit_q;
	assign tx_seq       = tx_seq_q;
	assign tx_ack       = tx_ack_q;
	assign is_retry     = is_retry_q;
	assign rx_status    = rx_status_q;
	assign deliver      = deliver_out_q;
	assign acked_count  = acked_out_q;
	assign sending_done = sending_done_q;
	assign receiving    = receiving_q;
	assign last         = last_q;

endmodule

FILE: src/gbn_checker.sv
module gbn_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         transmit,
	input logic [gbn_pkg::SEQ_W-1:0]    tx_seq,
	input logic                         is_retry,
	input logic [gbn_pkg::STAT_W-1:0]   rx_status,
	input logic                         deliver,
	input logic [gbn_pkg::SEQ_W-1:0]    acked_count,
	input logic                         last
);
	import gbn_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	a_idle_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !transmit |-> tx_seq == '0)
		else $error("sequence number on a word without transmit");

	a_retry_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_retry |-> transmit && rx_status == ST_OK && !deliver
			&& acked_count == '0)
		else $error("retransmit word carries receive fields");

	a_deliver_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && deliver |-> rx_status == ST_OK)
		else $error("delivery on a bad frame");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last && !out_stall |=> out_valid && is_retry)
		else $error("retransmit burst broken");

endmodule

bind go_back_n_window_controller gbn_checker u_gbn_checker (.*);

FILE: bench/go_back_n_window_controller_tb.sv
module go_back_n_window_controller_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import gbn_pkg::*;

	// Give up long after the slowest legal run: full retransmit bursts, each result
	// word held by the longest receiver stall, plus sender gaps.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_WORDS = 44;
	localparam int DRAIN_CYCLES = 64;
	localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

	// One input word: a link event
	typedef struct {
		op_t   op;
		seq_t  rx_seq;
		seq_t  rx_ack;
		logic  rx_ok;
		kind_t rx_kind;
		logic  new_is_end;
	} frame_event_t;

	// One result word
	typedef struct {
		logic    transmit;
		seq_t    tx_seq;
		seq_t    tx_ack;
		logic    is_retry;
		status_t rx_status;
		logic    deliver;
		seq_t    acked_count;
		logic    sending_done;
		logic    receiving;
		logic    last;
	} link_result_t;

	// Sequence state of the link plus the window register
	typedef struct {
		logic [SEQ_W-1:0] win;
		seq_t             exp_rx;
		seq_t             nxt_tx;
		seq_t             oldest;
		seq_t             outst;
		seq_t             end_s;
		logic             end_v;
		logic             snd_act;
		logic             rcv_act;
	} link_state_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [SEQ_W-1:0]    rx_seq;
	logic [SEQ_W-1:0]    rx_ack;
	logic                rx_ok;
	logic [KIND_W-1:0]   rx_kind;
	logic                new_is_end;
	logic                out_valid;
	logic                out_stall;
	logic                transmit;
	logic [SEQ_W-1:0]    tx_seq;
	logic [SEQ_W-1:0]    tx_ack;
	logic                is_retry;
	logic [STAT_W-1:0]   rx_status;
	logic                deliver;
	logic [SEQ_W-1:0]    acked_count;
	logic                sending_done;
	logic                receiving;
	logic                last;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// seq_state follows accepted words; plan_state runs ahead with the generator
	link_state_t  seq_state;
	link_state_t  plan_state;
	frame_event_t event_queue[$];
	link_result_t due_words[$];
	frame_event_t held_event;
	logic         word_taken;
	logic         sender_quiet;
	int           burst_left;
	int           gap_left;
	logic [15:0]  stall_bits;
	logic [7:0]   stall_tick;
	int           cycle_count;
	int           mismatches;
	int           words_in;
	int           words_checked;
	int           windows_tried;
	int           longest_run;

	go_back_n_window_controller i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.rx_seq       (rx_seq),
		.rx_ack       (rx_ack),
		.rx_ok        (rx_ok),
		.rx_kind      (rx_kind),
		.new_is_end   (new_is_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.transmit     (transmit),
		.tx_seq       (tx_seq),
		.tx_ack       (tx_ack),
		.is_retry     (is_retry),
		.rx_status    (rx_status),
		.deliver      (deliver),
		.acked_count  (acked_count),
		.sending_done (sending_done),
		.receiving    (receiving),
		.last         (last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// ---------------------------------------------------------------- predictor

	// Sequence modulus: window clamped to 1..MAX_WINDOW, plus one
	function automatic int modulus(link_state_t s);
		int w;
		w = int'(s.win);
		if (w < 1) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		return w + 1;
	endfunction

	// Circular increment; a number left above the modulus by a shrink wraps to 0
	function automatic seq_t seq_step(link_state_t s, seq_t x);
		return (int'(x) + 1 >= modulus(s)) ? seq_t'(0) : seq_t'(int'(x) + 1);
	endfunction

	function automatic link_result_t make_result(link_state_t s, logic tx, seq_t seq,
			logic retry, status_t st, logic dlv, seq_t acked, logic fin);
		link_result_t r;
		int m;
		int e;
		m = modulus(s);
		e = int'(s.exp_rx) % m;
		r.transmit     = tx;
		r.tx_seq       = seq;
		r.tx_ack       = seq_t'((e + m - 1) % m);
		r.is_retry     = retry;
		r.rx_status    = st;
		r.deliver      = dlv;
		r.acked_count  = acked;
		r.sending_done = s.end_v && (s.oldest == s.end_s);
		r.receiving    = s.rcv_act;
		r.last         = fin;
		return r;
	endfunction

	// Apply one link event to the state and append the result words it produces
	function automatic void link_step(ref link_state_t s, input frame_event_t w,
			ref link_result_t due[$]);
		status_t st;
		seq_t    acked;
		seq_t    idx;
		int      n;
		acked = '0;
		case (w.op)
			OP_RX: begin
				if (!w.rx_ok) st = ST_DATA_ERR;
				else if (w.rx_seq != s.exp_rx) st = ST_SEQ_ERR;
				else st = ST_OK;
				if (st == ST_OK) begin
					if (w.rx_kind == KIND_START) s.rcv_act = 1'b1;
					else if (w.rx_kind == KIND_END) s.rcv_act = 1'b0;
					s.exp_rx = seq_step(s, s.exp_rx);
					// release frames while the ack lies in [oldest, next) circularly
					while (s.outst > 0 &&
							((s.oldest <= w.rx_ack && w.rx_ack < s.nxt_tx) ||
							(s.nxt_tx < s.oldest && s.oldest <= w.rx_ack) ||
							(w.rx_ack < s.nxt_tx && s.nxt_tx < s.oldest))) begin
						s.outst--;
						acked++;
						s.oldest = seq_step(s, s.oldest);
					end
					if (s.end_v && s.oldest == s.end_s) s.snd_act = 1'b0;
				end
				due.insert(due.size(),
					make_result(s, 1'b0, '0, 1'b0, st, st == ST_OK, acked, 1'b1));
			end
			OP_SEND: begin
				if (int'(s.outst) < modulus(s) - 1) begin
					if (w.new_is_end) begin
						s.end_s = s.nxt_tx;
						s.end_v = 1'b1;
					end
					s.snd_act = 1'b1;
					due.insert(due.size(),
						make_result(s, 1'b1, s.nxt_tx, 1'b0, ST_OK, 1'b0, '0, 1'b1));
					s.nxt_tx = seq_step(s, s.nxt_tx);
					s.outst++;
				end else begin
					due.insert(due.size(),
						make_result(s, 1'b0, '0, 1'b0, ST_OK, 1'b0, '0, 1'b1));
				end
			end
			OP_TIMEOUT: begin
				n = (int'(s.outst) > MAX_WINDOW) ? MAX_WINDOW : int'(s.outst);
				if (n == 0) begin
					due.insert(due.size(),
						make_result(s, 1'b0, '0, 1'b0, ST_OK, 1'b0, '0, 1'b1));
				end else begin
					idx = s.oldest;
					for (int i = 0; i < n; i++) begin
						due.insert(due.size(), make_result(s, 1'b1, idx, 1'b1, ST_OK,
							1'b0, '0, i == n - 1));
						idx = seq_step(s, idx);
					end
					s.nxt_tx = idx;
				end
			end
			default: begin
				due.insert(due.size(),
					make_result(s, 1'b0, '0, 1'b0, ST_OK, 1'b0, '0, 1'b1));
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- driver

	// Take the word at the edge where it is accepted and predict its results
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			link_step(seq_state, held_event, due_words);
			words_in++;
			word_taken = 1'b1;
		end
	end

	// Present the next queued word once the current one is gone; hold it otherwise.
	// Words go out in bursts with random gaps, unless the phase runs the sender quiet.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || word_taken)) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (event_queue.size() > 0) begin
				held_event = event_queue.pop_front();
				op         <= held_event.op;
				rx_seq     <= held_event.rx_seq;
				rx_ack     <= held_event.rx_ack;
				rx_ok      <= held_event.rx_ok;
				rx_kind    <= held_event.rx_kind;
				new_is_end <= held_event.new_is_end;
				in_valid   <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 7);
					gap_left = sender_quiet ? 0 : $urandom_range(1, 5);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: a rotating 16-bit pattern, renewed whenever the 8-bit tick
	// wraps. Bit 0 is cleared on load so a stall never spans the whole rotation; a third
	// of the patterns are all zero, which gives stretches without backpressure.
	always @(negedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick == 8'd0) begin
			stall_bits <= ($urandom_range(0, 2) == 0) ? 16'h0000 : (16'($urandom) & 16'hFFFE);
		end else begin
			stall_bits <= {stall_bits[0], stall_bits[15:1]};
		end
		out_stall <= stall_bits[0];
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare each accepted result word with the oldest one still due
	always @(posedge clk) begin
		link_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_words.size() == 0) begin
				$display("%0t: result word with nothing due (transmit %0b tx_seq %0d)",
					$time, transmit, tx_seq);
				mismatches++;
			end else begin
				want = due_words.pop_front();
				check_field("transmit", 8'(want.transmit), 8'(transmit));
				check_field("tx_seq", 8'(want.tx_seq), 8'(tx_seq));
				check_field("tx_ack", 8'(want.tx_ack), 8'(tx_ack));
				check_field("is_retry", 8'(want.is_retry), 8'(is_retry));
				check_field("rx_status", 8'(want.rx_status), 8'(rx_status));
				check_field("deliver", 8'(want.deliver), 8'(deliver));
				check_field("acked_count", 8'(want.acked_count), 8'(acked_count));
				check_field("sending_done", 8'(want.sending_done), 8'(sending_done));
				check_field("receiving", 8'(want.receiving), 8'(receiving));
				check_field("last", 8'(want.last), 8'(last));
				words_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic frame_event_t word_of(op_t o, int seq, int ack, logic ok,
			kind_t kind, logic fin);
		frame_event_t w;
		w.op         = o;
		w.rx_seq     = seq_t'(seq);
		w.rx_ack     = seq_t'(ack);
		w.rx_ok      = ok;
		w.rx_kind    = kind;
		w.new_is_end = fin;
		return w;
	endfunction

	// Queue a word and advance the look-ahead state so later words can be in order
	task automatic plan_word(input frame_event_t w);
		link_result_t scratch[$];
		link_step(plan_state, w, scratch);
		if (scratch.size() > longest_run) longest_run = scratch.size();
		event_queue.insert(event_queue.size(), w);
	endtask

	// Wait until every queued word is accepted and every due result has arrived
	task automatic drain_words();
		@(posedge clk);
		while (event_queue.size() != 0 || in_valid || due_words.size() != 0)
			@(posedge clk);
	endtask

	// Write the window register (junk in the upper bits), then read it back
	task automatic write_window(input int setting);
		logic [PDATA_W-1:0] value;
		value = $urandom();
		value[SEQ_W-1:0] = SEQ_W'(setting);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= WINDOW_ADDR;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		seq_state.win  = value[SEQ_W-1:0];
		plan_state.win = value[SEQ_W-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== PDATA_W'(value[SEQ_W-1:0])) begin
			$display("%0t: window readback expected %0d, got %0d", $time,
				value[SEQ_W-1:0], prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		windows_tried++;
	endtask

	initial begin
		frame_event_t w;
		int           wv;
		int           fill;
		int           n;
		int           m;
		int           k;
		int           r;

		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = '0;
		rx_seq       = '0;
		rx_ack       = '0;
		rx_ok        = 1'b0;
		rx_kind      = '0;
		new_is_end   = 1'b0;
		out_stall    = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		word_taken   = 1'b0;
		sender_quiet = 1'b0;
		burst_left   = 0;
		gap_left     = 0;
		stall_bits   = '0;
		stall_tick   = 8'd1;
		cycle_count  = 0;
		mismatches   = 0;
		words_in     = 0;
		words_checked = 0;
		windows_tried = 0;
		longest_run  = 0;

		// Reset state: all sequence numbers zero, window 10
		seq_state.win     = WINDOW_RESET;
		seq_state.exp_rx  = '0;
		seq_state.nxt_tx  = '0;
		seq_state.oldest  = '0;
		seq_state.outst   = '0;
		seq_state.end_s   = '0;
		seq_state.end_v   = 1'b0;
		seq_state.snd_act = 1'b0;
		seq_state.rcv_act = 1'b0;
		plan_state        = seq_state;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at window 2 (modulus 3) so the window fills fast
		write_window(2);
		plan_word(word_of(OP_RX, 0, 0, 1'b0, KIND_DATA, 1'b0));      // data error
		plan_word(word_of(OP_RX, 31, 31, 1'b1, KIND_DATA, 1'b0));    // sequence error
		plan_word(word_of(OP_RX, 0, 0, 1'b1, KIND_START, 1'b1));     // start, receive on
		plan_word(word_of(OP_TIMEOUT, 31, 31, 1'b1, KIND_OTHER, 1'b1)); // nothing to resend
		plan_word(word_of(OP_SEND, 0, 0, 1'b0, KIND_START, 1'b0));
		plan_word(word_of(OP_SEND, 31, 31, 1'b1, KIND_OTHER, 1'b0));
		plan_word(word_of(OP_SEND, 0, 0, 1'b0, KIND_START, 1'b1));   // window full
		plan_word(word_of(OP_TIMEOUT, 0, 0, 1'b0, KIND_START, 1'b0)); // resend two
		plan_word(word_of(OP_RX, 1, 0, 1'b1, KIND_DATA, 1'b0));      // release one
		plan_word(word_of(OP_SEND, 0, 0, 1'b0, KIND_DATA, 1'b1));    // end frame
		plan_word(word_of(OP_RX, 2, 1, 1'b1, KIND_OTHER, 1'b0));     // predecessors acked
		plan_word(word_of(OP_RX, 0, 2, 1'b1, KIND_END, 1'b0));       // end, receive off
		plan_word(word_of(OP_RX, 1, 31, 1'b1, KIND_START, 1'b0));    // ack out of range
		plan_word(word_of(OP_NONE, 31, 31, 1'b1, KIND_OTHER, 1'b1)); // unused op
		plan_word(word_of(OP_SEND, 0, 0, 1'b0, KIND_DATA, 1'b0));
		plan_word(word_of(OP_SEND, 0, 0, 1'b0, KIND_DATA, 1'b0));    // two left outstanding

		// Random phases; each starts from the state the last one left, so the first
		// write shrinks the window below the frames still outstanding
		for (int ph = 0; ph < 9; ph++) begin
			drain_words();
			case (ph)
				0: wv = 1;
				1: wv = MAX_WINDOW;
				2: wv = 0;
				3: wv = 31;
				4: wv = 5;
				5: wv = 13;
				6: wv = $urandom_range(1, MAX_WINDOW);
				7: wv = $urandom_range(0, 31);
				default: wv = 3;
			endcase
			write_window(wv);
			sender_quiet = ($urandom_range(0, 3) == 0);

			// fill the window, overrun it once, then time out: longest retransmit run
			fill = modulus(plan_state);
			for (int i = 0; i < fill; i++)
				plan_word(word_of(OP_SEND, $urandom, $urandom, 1'($urandom),
					kind_t'($urandom_range(0, 3)), $urandom_range(0, 7) == 0));
			plan_word(word_of(OP_TIMEOUT, $urandom, $urandom, 1'($urandom),
				kind_t'($urandom_range(0, 3)), 1'($urandom)));

			n = fill + 1;
			while (n < PHASE_WORDS) begin
				m = modulus(plan_state);
				r = $urandom_range(0, 99);
				w = word_of(op_t'($urandom_range(0, 2)), $urandom, $urandom, 1'($urandom),
					kind_t'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
				if (r < 36) begin
					// good in-order frame acking a random number of outstanding frames
					k = $urandom_range(0, int'(plan_state.outst));
					w.op     = OP_RX;
					w.rx_ok  = 1'b1;
					w.rx_seq = plan_state.exp_rx;
					w.rx_ack = seq_t'((int'(plan_state.oldest) + k + m - 1) % m);
					if (r < 28) w.rx_kind = KIND_DATA;
				end else if (r < 66) begin
					w.op = OP_SEND;
				end else if (r < 76) begin
					w.op = OP_TIMEOUT;
				end else if (r < 86) begin
					// out-of-order but intact frame
					w.op     = OP_RX;
					w.rx_ok  = 1'b1;
					w.rx_seq = seq_t'((int'(plan_state.exp_rx) + $urandom_range(1, m - 1)) % m);
				end else if (r < 94) begin
					w.op    = OP_RX;
					w.rx_ok = 1'b0;
				end else begin
					w.op = op_t'($urandom_range(0, 3));
				end
				if (w.op != OP_NONE) n++;
				plan_word(w);
			end
		end

		drain_words();
		// let any stray result word show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d link events through %0d window writes; %0d result words checked.",
			words_in, windows_tried, words_checked);
		$display("Longest retransmit run: %0d words.", longest_run);
		if (mismatches == 0) begin
			$display("PASS go_back_n_window_controller");
		end else begin
			$display("FAIL go_back_n_window_controller");
		end
		$finish;
	end

	// Watchdog: a hung handshake or a missing result ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles with %0d result words still due.",
			cycle_count, due_words.size());
		$display("FAIL go_back_n_window_controller");
		$finish;
	end

endmodule
